// ===== rtl/gyi_pkg.sv =====
// Shared types and constants for the gyro yaw integrator.
package gyi_pkg;

   localparam int RAW_W   = 16;   // gyro sample width
   localparam int SUM_W   = 24;   // calibration sum width
   localparam int YAW_W   = 41;   // yaw accumulator, unsigned Q9.32
   localparam int FRAC_W  = 32;
   localparam int OUT_W   = 25;   // reported yaw, unsigned Q9.16
   localparam int DEG_W   = 9;
   localparam int DB_W    = 15;
   localparam int GAIN_W  = 24;
   localparam int PROD_W  = RAW_W + GAIN_W + 1;

   localparam logic [DEG_W-1:0]  FULL_TURN_DEG = DEG_W'(360);
   localparam logic [YAW_W:0]    FULL_TURN_Q32 = (YAW_W + 1)'(360) << FRAC_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // register map, word index into the CSR space
   localparam logic [1:0] REG_DEADBAND    = 2'd0;
   localparam logic [1:0] REG_RATE_GAIN   = 2'd1;
   localparam logic [1:0] REG_INITIAL_YAW = 2'd2;

   localparam logic [DB_W-1:0]   DEADBAND_RST    = DB_W'(60);
   localparam logic [GAIN_W-1:0] RATE_GAIN_RST   = GAIN_W'(4032678);
   localparam logic [DEG_W-1:0]  INITIAL_YAW_RST = DEG_W'(90);

   // one classified sample handed from front to back
   typedef struct packed {
      logic                    cal;       // bias sample
      logic                    cal_last;  // final bias sample: reload yaw
      logic signed [RAW_W-1:0] rate;      // corrected rate, zero inside deadband
   } entry_type;

   // fold an out-of-range start angle back into [0, 360)
   function automatic logic [DEG_W-1:0] start_deg(input logic [DEG_W-1:0] deg);
      logic [DEG_W-1:0] r;
      r = deg;
      if (deg >= FULL_TURN_DEG) begin
         r = deg - FULL_TURN_DEG;
      end
      return r;
   endfunction

endpackage

// ===== rtl/gyi_queue.sv =====
// Small register queue between the classify front and the integrate back.
module gyi_queue
   import gyi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      full,
   output logic      empty
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/gyi_front.sv =====
// Front end: sample intake, bias calibration with reciprocal divide, deadband classify.
module gyi_front
   import gyi_pkg::*;
#(
   parameter int CAL_SAMPLES = 200
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [RAW_W-1:0] req_gyro_z_raw,
   input  logic [DB_W-1:0]         deadband,
   input  logic                    queue_full,
   output logic                    push,
   output entry_type               push_entry
);

   localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);

   // floor(x / CAL_SAMPLES) = (x * RECIP_K) >> RECIP_SHIFT for every 24-bit x
   localparam int     RECIP_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
   localparam int     RECIP_W     = SUM_W + 1;
   localparam longint RECIP_VAL   = ((longint'(1) << RECIP_SHIFT) + longint'(CAL_SAMPLES) - 1)
                                    / longint'(CAL_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP_VAL);

   typedef enum logic [2:0] {
      ST_CAL = 3'b001,
      ST_DIV = 3'b010,
      ST_RUN = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [SUM_W-1:0]     cal_sum_ff, cal_sum_in;
   logic [CNT_W-1:0]            cal_count_ff, cal_count_in;
   logic signed [RAW_W-1:0]     bias_ff, bias_in;
   logic [SUM_W-1:0]            div_src_ff, div_src_in;
   logic                        div_neg_ff, div_neg_in;

   logic                        accept;
   logic signed [SUM_W-1:0]     sum_next;
   logic [SUM_W+RECIP_W-1:0]    quo_prod;
   logic [RAW_W-1:0]            quo_mag;
   logic signed [RAW_W-1:0]     d;
   logic [RAW_W:0]              mag;

   assign req_ready = ((state_ff == ST_CAL) || (state_ff == ST_RUN)) && !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept;

   assign sum_next  = cal_sum_ff + SUM_W'(req_gyro_z_raw);
   assign quo_prod  = div_src_ff * RECIP_K;
   assign quo_mag   = quo_prod[RECIP_SHIFT +: RAW_W];

   // corrected rate, 16-bit wrap; magnitude one bit wider for full-scale negative
   assign d   = req_gyro_z_raw - bias_ff;
   assign mag = d[RAW_W-1] ? ((RAW_W + 1)'(0) - {d[RAW_W-1], d})
                           : {1'b0, d};

   always_comb begin
      state_in     = state_ff;
      cal_sum_in   = cal_sum_ff;
      cal_count_in = cal_count_ff;
      bias_in      = bias_ff;
      div_src_in   = div_src_ff;
      div_neg_in   = div_neg_ff;

      push_entry.cal      = 1'b0;
      push_entry.cal_last = 1'b0;
      push_entry.rate     = '0;

      case (state_ff)
         ST_CAL: begin
            push_entry.cal      = 1'b1;
            push_entry.cal_last = (cal_count_ff == CNT_LAST);
            if (accept) begin
               cal_sum_in   = sum_next;
               cal_count_in = cal_count_ff + 1'b1;
               if (cal_count_ff == CNT_LAST) begin
                  // start the bias divide on the magnitude of the sum
                  state_in    = ST_DIV;
                  div_neg_in  = sum_next[SUM_W-1];
                  div_src_in  = sum_next[SUM_W-1] ? (SUM_W'(0) - sum_next) : sum_next;
               end
            end
         end
         ST_DIV: begin
            // reciprocal multiply, then restore the sign: truncation toward zero
            bias_in  = div_neg_ff ? (RAW_W'(0) - quo_mag) : quo_mag;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (mag >= (RAW_W + 1)'(deadband)) begin
               push_entry.rate = d;
            end
         end
         default: begin
            state_in = ST_CAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CAL;
         cal_sum_ff   <= '0;
         cal_count_ff <= '0;
         bias_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cal_sum_ff   <= cal_sum_in;
         cal_count_ff <= cal_count_in;
         bias_ff      <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      div_src_ff  <= div_src_in;
      div_neg_ff  <= div_neg_in;
   end

endmodule

// ===== rtl/gyi_back.sv =====
// Back end: gain multiply stage, yaw accumulate and wrap, result register.
module gyi_back
   import gyi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  entry_type         pop_entry,
   output logic              pop,
   input  logic [GAIN_W-1:0] rate_gain,
   input  logic [DEG_W-1:0]  initial_yaw,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OUT_W-1:0]  rsp_yaw_q16,
   output logic              rsp_calibrating
);

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_cal_ff, s1_last_ff;
   logic signed [PROD_W-1:0] s1_prod_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]         rsp_yaw_ff, rsp_yaw_in;
   logic                     rsp_cal_ff;
   logic [YAW_W-1:0]         yaw_acc_ff, yaw_acc_in;

   logic                     s1_ready;
   logic                     advance;
   logic [DEG_W-1:0]         deg;
   logic signed [YAW_W:0]    y_sum;
   logic signed [YAW_W:0]    y_wrap;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_ready = !s1_valid_ff || advance;
   assign pop      = !queue_empty && s1_ready;
   assign deg      = start_deg(initial_yaw);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_yaw_q16     = rsp_yaw_ff;
   assign rsp_calibrating = rsp_cal_ff;

   // step is below 128 degrees, one correction brings the sum back into range
   assign y_sum = $signed({1'b0, yaw_acc_ff}) + $signed({s1_prod_ff[PROD_W-1], s1_prod_ff});

   always_comb begin
      y_wrap = y_sum;
      if (y_sum >= $signed(FULL_TURN_Q32)) begin
         y_wrap = y_sum - $signed(FULL_TURN_Q32);
      end else if (y_sum[YAW_W]) begin
         y_wrap = y_sum + $signed(FULL_TURN_Q32);
      end
   end

   always_comb begin
      s1_valid_in  = pop ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      yaw_acc_in   = yaw_acc_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      if (advance) begin
         if (s1_cal_ff) begin
            rsp_yaw_in = {deg, 16'b0};
            if (s1_last_ff) begin
               yaw_acc_in = {deg, 32'b0};
            end
         end else begin
            yaw_acc_in = y_wrap[YAW_W-1:0];
            rsp_yaw_in = y_wrap[YAW_W-1:FRAC_W-16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         yaw_acc_ff   <= {start_deg(INITIAL_YAW_RST), 32'b0};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         yaw_acc_ff   <= yaw_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_cal_ff  <= pop_entry.cal;
         s1_last_ff <= pop_entry.cal_last;
         s1_prod_ff <= pop_entry.rate * $signed({1'b0, rate_gain});
      end
      rsp_yaw_ff <= rsp_yaw_in;
      if (advance) begin
         rsp_cal_ff <= s1_cal_ff;
      end
   end

endmodule

// ===== rtl/gyro_yaw_integrator.sv =====
// Top level of the gyro yaw integrator: CSR block, front, queue and back.
//
//  channel  | direction | handshake            | payload
//  req_*    | in        | req_valid/req_ready  | req_gyro_z_raw (s16)
//  rsp_*    | out       | rsp_valid/rsp_ready  | rsp_yaw_q16 (u25 Q9.16), rsp_calibrating
//  CSR      | in/out    | psel/penable/pready  | paddr, pwdata, prdata (32 bit)
//
// Sustained rate is one transaction per cycle while rsp_ready stays high and no bias
// divide is under way; an accepted req goes to a queue slot, then the gain multiply
// register, then the yaw accumulate and result register, which drives rsp_valid.
// After the last calibration sample the bias is formed by one reciprocal multiply
// in the divide state, and req_ready stays low for that state only.
// Reset is synchronous and clears control state; no clearing pass is needed.
// rsp stalls back up through the multiply stage into the four-entry queue; req
// keeps flowing until the queue fills.
module gyro_yaw_integrator
   import gyi_pkg::*;
#(
   parameter int CAL_SAMPLES = 200
)
(
   input  logic                    clock,
   input  logic                    reset,
   // sample input
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [RAW_W-1:0] req_gyro_z_raw,
   // result output
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OUT_W-1:0]        rsp_yaw_q16,
   output logic                    rsp_calibrating,
   // CSR port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic [DB_W-1:0]   deadband_ff, deadband_in;
   logic [GAIN_W-1:0] rate_gain_ff, rate_gain_in;
   logic [DEG_W-1:0]  initial_yaw_ff, initial_yaw_in;

   logic              csr_write;
   logic [1:0]        csr_index;

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;
   entry_type         push_entry;
   entry_type         pop_entry;

   // no wait states on the CSR port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   // write decode: keep the low bits of each field, drop writes past the map
   always_comb begin
      deadband_in    = deadband_ff;
      rate_gain_in   = rate_gain_ff;
      initial_yaw_in = initial_yaw_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DEADBAND:    deadband_in    = pwdata[DB_W-1:0];
            REG_RATE_GAIN:   rate_gain_in   = pwdata[GAIN_W-1:0];
            REG_INITIAL_YAW: initial_yaw_in = pwdata[DEG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // read mux, zero-extended fields
   always_comb begin
      case (csr_index)
         REG_DEADBAND:    prdata = 32'(deadband_ff);
         REG_RATE_GAIN:   prdata = 32'(rate_gain_ff);
         REG_INITIAL_YAW: prdata = 32'(initial_yaw_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff    <= DEADBAND_RST;
         rate_gain_ff   <= RATE_GAIN_RST;
         initial_yaw_ff <= INITIAL_YAW_RST;
      end else begin
         deadband_ff    <= deadband_in;
         rate_gain_ff   <= rate_gain_in;
         initial_yaw_ff <= initial_yaw_in;
      end
   end

   // front: accept, calibrate bias, subtract it and apply the deadband
   gyi_front #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_gyro_z_raw (req_gyro_z_raw),
      .deadband       (deadband_ff),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   // decouple the two halves so each can stall on its own
   gyi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // back: scale by the gain, integrate, wrap into one turn, hold the result
   gyi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .rate_gain       (rate_gain_ff),
      .initial_yaw     (initial_yaw_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_yaw_q16     (rsp_yaw_q16),
      .rsp_calibrating (rsp_calibrating)
   );

endmodule

// ===== rtl/gyi_checker.sv =====
// Port-level checks for the gyro yaw integrator, bound to the top level.
module gyi_checker
   import gyi_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] rsp_yaw_q16,
   input logic             rsp_calibrating
);

   localparam logic [OUT_W-1:0] FULL_TURN_Q16 = OUT_W'(360) << 16;

   logic running_ff, running_in;

   // set once a non-calibration result has been delivered
   assign running_in = running_ff || (rsp_valid && rsp_ready && !rsp_calibrating);

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_yaw_q16)
                                  && $stable(rsp_calibrating))
      else $error("rsp transaction changed while stalled");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_yaw_q16 < FULL_TURN_Q16)
      else $error("yaw outside one turn");

   a_cal_done: assert property (@(posedge clock) disable iff (reset)
      running_ff && rsp_valid |-> !rsp_calibrating)
      else $error("calibration result after integration started");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind gyro_yaw_integrator gyi_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_yaw_q16     (rsp_yaw_q16),
   .rsp_calibrating (rsp_calibrating)
);
